// ----- hdl/dfs_pkg.sv -----
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants of the frame difference span finder
// Holds the configuration record, the span record and the limits of the
// display geometry.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int MaxColumns = 128;
  localparam int MaxRows    = 8;

  localparam int ColW   = 7;   // column counter and span start
  localparam int RowW   = 3;   // row counter and span row
  localparam int LenW   = 8;   // run and span lengths (up to MaxColumns)
  localparam int ByteW  = 8;
  localparam int CfgW   = 8;   // widest configuration register
  localparam int RegIdxW = 2;

  // Span queue between the tracker and the result side.
  localparam int QDepth = 4;
  localparam int QAddrW = 2;
  localparam int QCountW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_COLUMNS   = 2'd0,
    REG_ROWS      = 2'd1,
    REG_MERGE_GAP = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] columns_in_use;
    logic [3:0] rows_in_use;
    logic [7:0] merge_gap;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] start;
    logic [LenW-1:0] length;
    logic            last;
  } span_t;

  // Up to two spans written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    span_t      first;
    span_t      second;
  } span_wr_t;

endpackage

// ----- hdl/dfs_front.sv -----
// ----------------------------------------------------------------------------
// dfs_front: run and span tracker
// Compares each byte pair, follows the column and row position, grows runs,
// merges them into the current span and hands finished spans to the queue.
// ----------------------------------------------------------------------------
module dfs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [dfs_pkg::ByteW-1:0] new_byte,
  input  logic [dfs_pkg::ByteW-1:0] old_byte,
  input  dfs_pkg::cfg_t             cfg,
  output dfs_pkg::span_wr_t         wr
);

  logic [dfs_pkg::ColW-1:0] column_count, column_count_next;
  logic [dfs_pkg::RowW-1:0] row_count, row_count_next;
  logic                     in_run, in_run_next;
  logic [dfs_pkg::ColW-1:0] run_start, run_start_next;
  logic [dfs_pkg::LenW-1:0] run_length, run_length_next;
  logic [dfs_pkg::ColW-1:0] span_begin, span_begin_next;
  logic [dfs_pkg::LenW-1:0] span_size, span_size_next;

  logic [7:0]               cols_eff;
  logic [3:0]               rows_eff;
  logic                     row_end;
  logic                     differs;
  logic                     ir1;
  logic [dfs_pkg::ColW-1:0] rs1;
  logic [dfs_pkg::LenW-1:0] rl1;
  logic                     close_now;
  logic [8:0]               span_end;
  logic [8:0]               gap_seen;
  logic                     separate;
  logic                     emit_a;
  logic                     emit_b;
  logic [dfs_pkg::ColW-1:0] sb2;
  logic [dfs_pkg::LenW-1:0] ss2;
  dfs_pkg::span_t           span_a;
  dfs_pkg::span_t           span_b;

  always_comb begin
    // Clamp the geometry registers to their legal ranges.
    if (cfg.columns_in_use == 8'd0) begin
      cols_eff = 8'd1;
    end else if (cfg.columns_in_use > 8'(dfs_pkg::MaxColumns)) begin
      cols_eff = 8'(dfs_pkg::MaxColumns);
    end else begin
      cols_eff = cfg.columns_in_use;
    end
    if (cfg.rows_in_use == 4'd0) begin
      rows_eff = 4'd1;
    end else if (cfg.rows_in_use > 4'(dfs_pkg::MaxRows)) begin
      rows_eff = 4'(dfs_pkg::MaxRows);
    end else begin
      rows_eff = cfg.rows_in_use;
    end

    row_end = ({1'b0, column_count} + 8'd1) >= cols_eff;
    differs = new_byte != old_byte;

    // Run after this column's compare.
    if (differs && in_run) begin
      ir1 = 1'b1;
      rs1 = run_start;
      rl1 = run_length + 8'd1;
    end else if (differs) begin
      ir1 = 1'b1;
      rs1 = column_count;
      rl1 = 8'd1;
    end else begin
      ir1 = in_run;
      rs1 = run_start;
      rl1 = run_length;
    end

    // A run closes on an equal column or at the end of the row.
    close_now = ir1 && (!differs || row_end);
    span_end  = {2'b00, span_begin} + {1'b0, span_size};
    gap_seen  = {2'b00, rs1} - span_end;
    separate  = ({2'b00, rs1} >= span_end) && (gap_seen >= {1'b0, cfg.merge_gap});
    emit_a    = close_now && separate && (span_size != 8'd0);

    sb2 = span_begin;
    ss2 = span_size;
    if (close_now && separate) begin
      sb2 = rs1;
      ss2 = rl1;
    end else if (close_now) begin
      ss2 = ({1'b0, rs1} - {1'b0, span_begin}) + rl1;
    end

    emit_b = row_end && (ss2 != 8'd0);

    span_a.row    = row_count;
    span_a.start  = span_begin;
    span_a.length = span_size;
    span_a.last   = !emit_b;
    span_b.row    = row_count;
    span_b.start  = sb2;
    span_b.length = ss2;
    span_b.last   = 1'b1;

    wr.count  = 2'd0;
    wr.first  = span_a;
    wr.second = span_b;
    if (accept) begin
      if (emit_a && emit_b) begin
        wr.count = 2'd2;
      end else if (emit_a) begin
        wr.count = 2'd1;
      end else if (emit_b) begin
        wr.count = 2'd1;
        wr.first = span_b;
      end
    end

    if (row_end) begin
      column_count_next = '0;
      row_count_next    = (({1'b0, row_count} + 4'd1) >= rows_eff) ? '0 : row_count + 3'd1;
      in_run_next       = 1'b0;
      run_start_next    = '0;
      run_length_next   = '0;
      span_begin_next   = '0;
      span_size_next    = '0;
    end else begin
      column_count_next = column_count + 7'd1;
      row_count_next    = row_count;
      in_run_next       = ir1 && !close_now;
      run_start_next    = rs1;
      run_length_next   = rl1;
      span_begin_next   = sb2;
      span_size_next    = ss2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      in_run       <= 1'b0;
      run_start    <= '0;
      run_length   <= '0;
      span_begin   <= '0;
      span_size    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      in_run       <= in_run_next;
      run_start    <= run_start_next;
      run_length   <= run_length_next;
      span_begin   <= span_begin_next;
      span_size    <= span_size_next;
    end
  end

endmodule

// ----- hdl/dfs_span_queue.sv -----
// ----------------------------------------------------------------------------
// dfs_span_queue: span queue and result side
// Takes up to two spans per cycle from the tracker and presents them one at a
// time on the result side.
// ----------------------------------------------------------------------------
module dfs_span_queue (
  input  logic              clk,
  input  logic              rst,
  input  dfs_pkg::span_wr_t wr,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output dfs_pkg::span_t    head
);

  dfs_pkg::span_t                slots [dfs_pkg::QDepth];
  logic [dfs_pkg::QAddrW-1:0]    wptr;
  logic [dfs_pkg::QAddrW-1:0]    rptr;
  logic [dfs_pkg::QCountW-1:0]   count;
  logic                          take;
  logic [dfs_pkg::QAddrW-1:0]    wptr_plus;

  assign empty     = count == '0;
  // Room for a full burst of two spans must be kept.
  assign full      = count > dfs_pkg::QCountW'(dfs_pkg::QDepth - 2);
  assign take      = pop && !empty;
  assign head      = slots[rptr];
  assign wptr_plus = wptr + dfs_pkg::QAddrW'(1);

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      slots[wptr] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      slots[wptr_plus] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + dfs_pkg::QAddrW'(wr.count);
      if (take) begin
        rptr <= rptr + dfs_pkg::QAddrW'(1);
      end
      count <= count + dfs_pkg::QCountW'(wr.count) - dfs_pkg::QCountW'(take);
    end
  end

endmodule

// ----- hdl/frame_diff_span_finder.sv -----
// ----------------------------------------------------------------------------
// frame_diff_span_finder: changed-span detector for a paged display
// Compares new and shown frame bytes column by column and reports the spans
// of each row that must be resent, merging runs separated by small gaps.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Payload
//   input     in         push / full        new_byte, old_byte
//   result    out        empty / pop        span_row, span_start, span_length,
//                                           last_of_burst
//   config    in         cfg_write          cfg_index, cfg_data
//
// One byte pair is taken per cycle while not full; the tracker updates its
// run and span state in the cycle of the transfer and writes zero, one or two
// spans into a four-entry queue, so a result can be popped the cycle after
// its item. full rises while fewer than two queue entries are free, so a pair
// taken in any cycle always finds room for both of its spans; with a stalled
// pop no pair is taken while full is high. Reset is synchronous and clears
// the counters, the span state, the queue and restores the default registers.
// ----------------------------------------------------------------------------
module frame_diff_span_finder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [dfs_pkg::ByteW-1:0]   new_byte,
  input  logic [dfs_pkg::ByteW-1:0]   old_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [dfs_pkg::RowW-1:0]    span_row,
  output logic [dfs_pkg::ColW-1:0]    span_start,
  output logic [dfs_pkg::LenW-1:0]    span_length,
  output logic                        last_of_burst,
  input  logic                        cfg_write,
  input  logic [dfs_pkg::RegIdxW-1:0] cfg_index,
  input  logic [dfs_pkg::CfgW-1:0]    cfg_data
);

  dfs_pkg::cfg_t     cfg;
  dfs_pkg::span_wr_t wr;
  dfs_pkg::span_t    head;
  logic              accept;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns_in_use <= 8'd128;
      cfg.rows_in_use    <= 4'd8;
      cfg.merge_gap      <= 8'd8;
    end else if (cfg_write) begin
      unique case (dfs_pkg::reg_idx_t'(cfg_index))
        dfs_pkg::REG_COLUMNS:   cfg.columns_in_use <= cfg_data;
        dfs_pkg::REG_ROWS:      cfg.rows_in_use    <= cfg_data[3:0];
        dfs_pkg::REG_MERGE_GAP: cfg.merge_gap      <= cfg_data;
        default: ;
      endcase
    end
  end

  dfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .new_byte (new_byte),
    .old_byte (old_byte),
    .cfg      (cfg),
    .wr       (wr)
  );

  dfs_span_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  assign span_row      = head.row;
  assign span_start    = head.start;
  assign span_length   = head.length;
  assign last_of_burst = head.last;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the frame difference span finder
// A clocked driver feeds byte pairs from a queue in bursts, a clocked
// receiver pops spans on its own stall pattern, and the monitor tracks runs
// and merged spans in step with every accepted pair to check each span popped.
// ----------------------------------------------------------------------------
module tb;
  import dfs_pkg::*;

  localparam int StallLimit = 2000;
  localparam int TargetPairs = 2000;

  typedef struct packed {
    logic [ByteW-1:0] fresh_byte;
    logic [ByteW-1:0] shown_byte;
  } byte_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [ByteW-1:0]   new_byte = '0;
  logic [ByteW-1:0]   old_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [RowW-1:0]    span_row;
  logic [ColW-1:0]    span_start;
  logic [LenW-1:0]    span_length;
  logic               last_of_burst;
  logic               cfg_write = 1'b0;
  reg_idx_t           cfg_index = REG_COLUMNS;
  logic [CfgW-1:0]    cfg_data = '0;

  frame_diff_span_finder u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .new_byte      (new_byte),
    .old_byte      (old_byte),
    .empty         (empty),
    .pop           (pop),
    .span_row      (span_row),
    .span_start    (span_start),
    .span_length   (span_length),
    .last_of_burst (last_of_burst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  byte_pair_t     pending_pairs[$];
  span_t          spans_due[$];
  span_t          fresh_spans[$];
  int             mismatches = 0;

  // Raw register copies and the run/span tracking state.
  int unsigned    reg_columns, reg_rows, reg_gap;
  int unsigned    col_pos, row_pos, run_first, run_len, span_first, span_len;
  bit             run_open;

  function automatic void tracker_reset();
    reg_columns = MaxColumns;
    reg_rows = MaxRows;
    reg_gap = 8;
    col_pos = 0;
    row_pos = 0;
    run_open = 1'b0;
    run_first = 0;
    run_len = 0;
    span_first = 0;
    span_len = 0;
  endfunction

  function automatic void post_span();
    span_t s;
    s.row = RowW'(row_pos);
    s.start = ColW'(span_first);
    s.length = LenW'(span_len);
    s.last = 1'b0;
    fresh_spans.insert(fresh_spans.size(), s);
  endfunction

  // Folds a finished run into the merged span, sending the span first when
  // the gap between them is wide enough.
  function automatic void fold_run();
    int unsigned span_end;
    span_end = span_first + span_len;
    if (!run_open) return;
    run_open = 1'b0;
    if (run_first >= span_end && run_first - span_end >= reg_gap) begin
      if (span_len != 0) post_span();
      span_first = run_first;
      span_len = run_len;
    end else begin
      span_len = run_first - span_first + run_len;
    end
  endfunction

  function automatic void advance_tracker(logic [ByteW-1:0] fb, logic [ByteW-1:0] sb);
    int unsigned cols, rows;
    span_t s;
    cols = reg_columns;
    rows = reg_rows;
    if (cols == 0) cols = 1;
    if (cols > MaxColumns) cols = MaxColumns;
    if (rows == 0) rows = 1;
    if (rows > MaxRows) rows = MaxRows;
    fresh_spans.delete();
    if (fb != sb) begin
      if (run_open) begin
        run_len++;
      end else begin
        run_open = 1'b1;
        run_first = col_pos;
        run_len = 1;
      end
    end else begin
      fold_run();
    end
    if (col_pos + 1 >= cols) begin
      fold_run();
      if (span_len != 0) post_span();
      run_open = 1'b0;
      run_first = 0;
      run_len = 0;
      span_first = 0;
      span_len = 0;
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    foreach (fresh_spans[i]) begin
      s = fresh_spans[i];
      s.last = (i == fresh_spans.size() - 1);
      spans_due.insert(spans_due.size(), s);
    end
  endfunction

  function automatic void check_field(string label, int unsigned want, logic [LenW-1:0] got);
    if (got !== LenW'(want)) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // Driver: bursts of pairs with random gaps; a pair is held until its transfer.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : driver
    byte_pair_t pair;
    if (rst) begin
      push <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!push || !full) begin
      if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        pair = pending_pairs.pop_front();
        push <= 1'b1;
        new_byte <= pair.fresh_byte;
        old_byte <= pair.shown_byte;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 15))
            0, 1, 2, 3: gap_left = 0;
            15: gap_left = $urandom_range(20, 60);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: switches between free flow, random pops, sparse pops and a hard stall.
  int pop_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin : receiver
    if (rst) begin
      pop <= 1'b0;
      pop_mode = 0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= 1'b0;
      endcase
    end
  end

  // Monitor: checks popped spans, tracks register writes and accepted pairs.
  int stall_cycles = 0;

  always @(posedge clk) begin : monitor
    bit    moved;
    span_t want;
    if (rst) begin
      tracker_reset();
      spans_due.delete();
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        if (spans_due.size() == 0) begin
          $display("%0t: span transfer with none expected, got row %0d start %0d length %0d last %0d",
                   $time, span_row, span_start, span_length, last_of_burst);
          mismatches++;
        end else begin
          want = spans_due.pop_front();
          check_field("span_row", want.row, span_row);
          check_field("span_start", want.start, span_start);
          check_field("span_length", want.length, span_length);
          check_field("last_of_burst", want.last, last_of_burst);
        end
      end
      if (cfg_write) begin
        moved = 1'b1;
        case (cfg_index)
          REG_COLUMNS:   reg_columns = cfg_data;
          REG_ROWS:      reg_rows = cfg_data[3:0];
          REG_MERGE_GAP: reg_gap = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        moved = 1'b1;
        advance_tracker(new_byte, old_byte);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic void add_pair(bit differ, bit extreme);
    byte_pair_t p;
    if (extreme) begin
      if (differ) p = $urandom_range(0, 1) ? {8'hFF, 8'h00} : {8'h00, 8'hFF};
      else p = $urandom_range(0, 1) ? {8'hFF, 8'hFF} : {8'h00, 8'h00};
    end else begin
      p.fresh_byte = ByteW'($urandom);
      p.shown_byte = differ ? p.fresh_byte ^ ByteW'($urandom_range(1, 255)) : p.fresh_byte;
    end
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || push || spans_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  initial begin : stimulus
    // Two rows of twelve columns: a lone run past the merge gap, merged runs,
    // a run open at row end, and a row end that sends two spans at once.
    logic [23:0]     dmask;
    logic [CfgW-1:0] cols, gap;
    logic [3:0]      rows;
    int              total, phase, count, flip;
    bit              differ;
    dmask = 24'h7C3960;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_COLUMNS, 8'd12);
    write_reg(REG_ROWS, 8'd2);
    write_reg(REG_MERGE_GAP, 8'd4);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < 24; i++) add_pair(dmask[i], (i % 3) != 2);
    total = 24;
    phase = 0;
    while (total < TargetPairs) begin
      case (phase)
        0: begin cols = 8'd0; rows = 4'd0; gap = 8'd0; end
        1: begin cols = 8'd255; rows = 4'd15; gap = 8'd255; end
        2: begin cols = 8'd1; rows = 4'd1; gap = 8'd1; end
        3: begin cols = 8'd128; rows = 4'd8; gap = 8'd128; end
        default: begin
          cols = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(2, 24));
          rows = 4'($urandom_range(0, 15));
          gap = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 12));
        end
      endcase
      // Registers change only with nothing in flight; the row position
      // carries over, so a shrunk column count may cut the current row short.
      wait_drained();
      write_reg(REG_COLUMNS, cols);
      write_reg(REG_ROWS, {4'd0, rows});
      write_reg(REG_MERGE_GAP, gap);
      write_reg(REG_UNUSED, 8'($urandom));
      @(posedge clk);
      cfg_write <= 1'b0;
      @(negedge clk);
      count = (phase % 5 == 4) ? $urandom_range(1, 10) : $urandom_range(40, 250);
      case ($urandom_range(0, 4))
        0: flip = 2;
        1: flip = 10;
        2: flip = 30;
        3: flip = 60;
        default: flip = 95;
      endcase
      differ = 1'($urandom_range(0, 1));
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 99) < flip) differ = !differ;
        add_pair(differ, $urandom_range(0, 9) == 0);
      end
      total += count;
      phase++;
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- frame_diff_span_finder.f -----
hdl/dfs_pkg.sv
hdl/dfs_front.sv
hdl/dfs_span_queue.sv
hdl/frame_diff_span_finder.sv
tb/tb.sv
